// ===== rtl/lecf_pkg.sv =====
`timescale 1ns / 1ps
package lecf_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int POS_W    = 32;
	localparam int RAD_W    = 31;
	localparam int K_W      = 32;
	localparam int FORCE_W  = 48;
	localparam int ENERGY_W = 48;

	// square root: 32 result bits, four per stage
	localparam int ROOT_W     = 32;
	localparam int SQRT_STEPS = 4;
	// contact offset quotient: 32 bits, four per stage
	localparam int OFF_W      = 32;
	localparam int OFF_STEPS  = 4;
	// force quotient: 48 bits, six per stage
	localparam int FORCE_STEPS = 6;

	// width of the spring products before scaling
	localparam int PROD_W = 96;

endpackage

// ===== rtl/lecf_in_if.sv =====
`timescale 1ns / 1ps
interface lecf_in_if;
	logic valid;
	logic ready;
	logic signed [lecf_pkg::POS_W-1:0] first_x;
	logic signed [lecf_pkg::POS_W-1:0] first_y;
	logic signed [lecf_pkg::POS_W-1:0] first_z;
	logic        [lecf_pkg::RAD_W-1:0] first_radius;
	logic signed [lecf_pkg::POS_W-1:0] second_x;
	logic signed [lecf_pkg::POS_W-1:0] second_y;
	logic signed [lecf_pkg::POS_W-1:0] second_z;
	logic        [lecf_pkg::RAD_W-1:0] second_radius;

	modport source (
		output valid, first_x, first_y, first_z, first_radius,
		output second_x, second_y, second_z, second_radius,
		input  ready
	);
	modport sink (
		input  valid, first_x, first_y, first_z, first_radius,
		input  second_x, second_y, second_z, second_radius,
		output ready
	);
endinterface

// ===== rtl/lecf_out_if.sv =====
`timescale 1ns / 1ps
interface lecf_out_if;
	logic valid;
	logic ready;
	logic signed [lecf_pkg::FORCE_W-1:0]  force_x;
	logic signed [lecf_pkg::FORCE_W-1:0]  force_y;
	logic signed [lecf_pkg::FORCE_W-1:0]  force_z;
	logic signed [lecf_pkg::POS_W-1:0]    contact_x;
	logic signed [lecf_pkg::POS_W-1:0]    contact_y;
	logic signed [lecf_pkg::POS_W-1:0]    contact_z;
	logic                                 touching;
	logic        [lecf_pkg::ENERGY_W-1:0] spring_energy;

	modport source (
		output valid, force_x, force_y, force_z, contact_x, contact_y, contact_z,
		output touching, spring_energy,
		input  ready
	);
	modport sink (
		input  valid, force_x, force_y, force_z, contact_x, contact_y, contact_z,
		input  touching, spring_energy,
		output ready
	);
endinterface

// ===== rtl/lecf_sqrt.sv =====
`timescale 1ns / 1ps
module lecf_sqrt #(
	parameter int ROOT_W = 32,
	parameter int STEPS  = 4
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*ROOT_W-1:0] radicand,
	output logic [ROOT_W-1:0]   root
);

	localparam int N_ST  = ROOT_W / STEPS;
	localparam int REM_W = ROOT_W + 3;

	logic [2*ROOT_W-1:0] rad_s  [N_ST];
	logic [REM_W-1:0]    rem_s  [N_ST];
	logic [ROOT_W-1:0]   root_s [N_ST];

	logic [2*ROOT_W-1:0] rad_in  [N_ST];
	logic [REM_W-1:0]    rem_in  [N_ST];
	logic [ROOT_W-1:0]   root_in [N_ST];

	genvar k;
	for (k = 0; k < N_ST; k++) begin : g_st
		logic [2*ROOT_W-1:0] rad_nx;
		logic [REM_W-1:0]    rem_nx;
		logic [ROOT_W-1:0]   root_nx;

		if (k == 0) begin : g_first
			assign rad_in[k]  = radicand;
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
		end else begin : g_next
			assign rad_in[k]  = rad_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign root_in[k] = root_s[k-1];
		end

		// one result bit per step: bring down two radicand bits, try 4*root+1
		always_comb begin
			logic [2*ROOT_W-1:0] rad;
			logic [REM_W-1:0]    rem;
			logic [REM_W-1:0]    trial;
			logic [ROOT_W-1:0]   rt;
			rad = rad_in[k];
			rem = rem_in[k];
			rt  = root_in[k];
			for (int j = 0; j < STEPS; j++) begin
				rem   = {rem[REM_W-3:0], rad[2*ROOT_W-1 -: 2]};
				trial = REM_W'({rt, 2'b01});
				rad   = rad << 2;
				if (rem >= trial) begin
					rem = rem - trial;
					rt  = {rt[ROOT_W-2:0], 1'b1};
				end else begin
					rt  = {rt[ROOT_W-2:0], 1'b0};
				end
			end
			rad_nx  = rad;
			rem_nx  = rem;
			root_nx = rt;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_nx;
				rem_s[k]  <= rem_nx;
				root_s[k] <= root_nx;
			end
		end
	end

	assign root = root_s[N_ST-1];

endmodule

// ===== rtl/lecf_div.sv =====
`timescale 1ns / 1ps
module lecf_div #(
	parameter int REM_W = 32,
	parameter int QUO_W = 32,
	parameter int STEPS = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic [REM_W-1:0] rem_start,
	input  logic [QUO_W-1:0] num,
	input  logic [REM_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int N_ST = QUO_W / STEPS;

	// sh holds the numerator bits still to come at the top, quotient bits enter at the bottom
	logic [REM_W-1:0] rem_s [N_ST];
	logic [QUO_W-1:0] sh_s  [N_ST];
	logic [REM_W-1:0] den_s [N_ST];

	logic [REM_W-1:0] rem_in [N_ST];
	logic [QUO_W-1:0] sh_in  [N_ST];
	logic [REM_W-1:0] den_in [N_ST];

	genvar k;
	for (k = 0; k < N_ST; k++) begin : g_st
		logic [REM_W-1:0] rem_nx;
		logic [QUO_W-1:0] sh_nx;

		if (k == 0) begin : g_first
			assign rem_in[k] = rem_start;
			assign sh_in[k]  = num;
			assign den_in[k] = den;
		end else begin : g_next
			assign rem_in[k] = rem_s[k-1];
			assign sh_in[k]  = sh_s[k-1];
			assign den_in[k] = den_s[k-1];
		end

		always_comb begin
			logic [REM_W:0]   t;
			logic [REM_W-1:0] rem;
			logic [QUO_W-1:0] sh;
			rem = rem_in[k];
			sh  = sh_in[k];
			for (int j = 0; j < STEPS; j++) begin
				t  = {rem, sh[QUO_W-1]};
				sh = sh << 1;
				if (t >= {1'b0, den_in[k]}) begin
					t     = t - {1'b0, den_in[k]};
					sh[0] = 1'b1;
				end
				rem = t[REM_W-1:0];
			end
			rem_nx = rem;
			sh_nx  = sh;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_nx;
				sh_s[k]  <= sh_nx;
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quo = sh_s[N_ST-1];

endmodule

// ===== rtl/lecf_dly.sv =====
`timescale 1ns / 1ps
module lecf_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				pipe_s[k] <= pipe_s[k-1];
			end
		end
	end

	assign q = pipe_s[DEPTH-1];

endmodule

// ===== rtl/linear_elastic_contact_force_top.sv =====
// Stages in order: front, root, contact and spring, force quotient, output register.
// Throughput: one pair per cycle unless stalled; the depth comes from the 32-bit root
// (4 bits a stage) and the 48-bit force quotient (6 bits a stage), each eight stages
// long. A result held at the output stalls every stage at once; nothing is dropped.
// Reset clears the stage valid bits and the stiffness register; data is not reset.
`timescale 1ns / 1ps
module linear_elastic_contact_force_top #(
	parameter int FRAC_BITS = lecf_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lecf_pkg::K_W-1:0]  cfg_wr_data,
	lecf_in_if.sink                   pair,
	lecf_out_if.source                result
);

	localparam int FORCE_W  = lecf_pkg::FORCE_W;
	localparam int ENERGY_W = lecf_pkg::ENERGY_W;
	localparam int PROD_W   = lecf_pkg::PROD_W;
	localparam int SQ_LAT   = lecf_pkg::ROOT_W / lecf_pkg::SQRT_STEPS;
	localparam int FDIV_LAT = FORCE_W / lecf_pkg::FORCE_STEPS;
	localparam int N_STG    = 4 + SQ_LAT + 5 + FDIV_LAT + 1;
	localparam int NF_W     = PROD_W - FRAC_BITS;
	localparam int HI_W     = NF_W - FORCE_W;
	localparam int CMP_W    = (HI_W > 32) ? HI_W : 32;
	localparam int EN_W     = PROD_W - 2 * FRAC_BITS - 1;
	localparam int EX_W     = (EN_W > ENERGY_W) ? EN_W : ENERGY_W + 1;

	localparam logic [FORCE_W-1:0] FORCE_MAX     = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W-1:0] FORCE_MIN_MAG = {1'b1, {(FORCE_W-1){1'b0}}};

	typedef struct packed {
		logic             cand;
		logic [2:0]       neg;
		logic [2:0]       pos;
		logic [2:0][31:0] ad;
		logic [2:0][31:0] p2;
		logic [31:0]      rsum;
	} geo_t;

	typedef struct packed {
		logic             touch;
		logic             zd;
		logic [2:0]       neg;
		logic [2:0]       pos;
		logic [2:0][31:0] ad;
		logic [31:0]      ov;
		logic [31:0]      sep_len;
		logic [2:0][31:0] contact;
	} mid_t;

	typedef struct packed {
		logic                touch;
		logic                zd;
		logic [2:0]          pos;
		logic [2:0]          sat;
		logic [2:0][31:0]    contact;
		logic [ENERGY_W-1:0] energy;
	} fin_t;

	logic             adv;
	logic [N_STG:1]   vld_s;
	logic [31:0]      stiffness_q;

	logic [2:0][31:0] p1_in;
	logic [2:0][31:0] p2_in;

	logic [2:0][32:0] d_s1;
	logic [31:0]      rsum_s1;
	logic [2:0][31:0] p2_s1;
	logic [30:0]      r2_s1;

	logic [2:0][31:0] ad_c;
	logic             near_c;
	logic [2:0][31:0] ad_s2;
	logic [2:0]       neg_s2;
	logic [2:0]       pos_s2;
	logic             near_s2;
	logic [31:0]      rsum_s2;
	logic [2:0][31:0] p2_s2;
	logic [30:0]      r2_s2;

	logic [2:0][63:0] sq_s3;
	logic [2:0][62:0] offn_s3;
	logic [2:0][31:0] ad_s3;
	logic [2:0]       neg_s3;
	logic [2:0]       pos_s3;
	logic             near_s3;
	logic [31:0]      rsum_s3;
	logic [2:0][31:0] p2_s3;

	logic [65:0]      sum_s4;
	logic [2:0][62:0] offn_s4;
	logic [2:0][31:0] ad_s4;
	logic [2:0]       neg_s4;
	logic [2:0]       pos_s4;
	logic             near_s4;
	logic [31:0]      rsum_s4;
	logic [2:0][31:0] p2_s4;

	geo_t             geo_in;
	geo_t             geo_out;
	logic [31:0]      sep_len;
	logic [2:0][31:0] off;

	mid_t             mid_c;
	mid_t             m_s13;
	mid_t             m_s14;
	mid_t             m_s15;
	mid_t             m_s16;
	mid_t             m_s17;
	logic [63:0]      q_s14;
	logic [2:0][63:0] pl_s15;
	logic [2:0][63:0] ph_s15;
	logic [63:0]      el_s15;
	logic [63:0]      eh_s15;
	logic [2:0][NF_W-1:0] nf_s16;
	logic [EN_W-1:0]  en_s16;

	logic [2:0][31:0]         rem0_c;
	logic [2:0]               sat_c;
	logic [ENERGY_W-1:0]      energy_c;
	logic [2:0][31:0]         rem0_s17;
	logic [2:0][FORCE_W-1:0]  lo_s17;
	logic [2:0]               sat_s17;
	logic [ENERGY_W-1:0]      energy_s17;

	fin_t                     fin_in;
	fin_t                     fin_out;
	logic [2:0][FORCE_W-1:0]  quo;
	logic [2:0][FORCE_W-1:0]  force_c;

	logic [2:0][FORCE_W-1:0]  force_s26;
	logic [2:0][31:0]         contact_s26;
	logic                     touch_s26;
	logic [ENERGY_W-1:0]      energy_s26;

	// the whole pipe moves unless a result waits at the output
	assign adv        = !vld_s[N_STG] || result.ready;
	assign pair.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			stiffness_q <= '0;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[N_STG-1:1], pair.valid};
			end
			if (cfg_wr_en) begin
				stiffness_q <= cfg_wr_data;
			end
		end
	end

	assign p1_in = {pair.first_z, pair.first_y, pair.first_x};
	assign p2_in = {pair.second_z, pair.second_y, pair.second_x};

	always_comb begin
		logic [32:0] dabs;
		near_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			dabs    = d_s1[i][32] ? (33'd0 - d_s1[i]) : d_s1[i];
			ad_c[i] = dabs[31:0];
			if (ad_c[i] >= rsum_s1) begin
				near_c = 1'b0;
			end
		end
	end

	// front stages: difference, magnitude, squares, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= {p1_in[i][31], p1_in[i]} - {p2_in[i][31], p2_in[i]};
				p2_s1[i] <= p2_in[i];
			end
			rsum_s1 <= {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
			r2_s1   <= pair.second_radius;

			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= d_s1[i][32];
				pos_s2[i] <= !d_s1[i][32] && (d_s1[i] != '0);
			end
			ad_s2   <= ad_c;
			near_s2 <= near_c;
			rsum_s2 <= rsum_s1;
			p2_s2   <= p2_s1;
			r2_s2   <= r2_s1;

			for (int i = 0; i < 3; i++) begin
				sq_s3[i]   <= ad_s2[i] * ad_s2[i];
				offn_s3[i] <= r2_s2 * ad_s2[i];
			end
			ad_s3   <= ad_s2;
			neg_s3  <= neg_s2;
			pos_s3  <= pos_s2;
			near_s3 <= near_s2;
			rsum_s3 <= rsum_s2;
			p2_s3   <= p2_s2;

			sum_s4  <= 66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2]);
			offn_s4 <= offn_s3;
			ad_s4   <= ad_s3;
			neg_s4  <= neg_s3;
			pos_s4  <= pos_s3;
			near_s4 <= near_s3;
			rsum_s4 <= rsum_s3;
			p2_s4   <= p2_s3;
		end
	end

	// a sum past 64 bits can never be inside the radius sum
	always_comb begin
		geo_in.cand = near_s4 && (sum_s4[65:64] == 2'b00);
		geo_in.neg  = neg_s4;
		geo_in.pos  = pos_s4;
		geo_in.ad   = ad_s4;
		geo_in.p2   = p2_s4;
		geo_in.rsum = rsum_s4;
	end

	lecf_sqrt #(
		.ROOT_W (lecf_pkg::ROOT_W),
		.STEPS  (lecf_pkg::SQRT_STEPS)
	) u_sqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (sum_s4[63:0]),
		.root     (sep_len)
	);

	lecf_dly #(
		.W     ($bits(geo_t)),
		.DEPTH (SQ_LAT)
	) u_geo_dly (
		.clk (clk),
		.en  (adv),
		.d   (geo_in),
		.q   (geo_out)
	);

	genvar g;
	for (g = 0; g < 3; g++) begin : g_off
		lecf_div #(
			.REM_W (32),
			.QUO_W (lecf_pkg::OFF_W),
			.STEPS (lecf_pkg::OFF_STEPS)
		) u_off_div (
			.clk       (clk),
			.en        (adv),
			.rem_start ({1'b0, offn_s4[g][62:32]}),
			.num       (offn_s4[g][31:0]),
			.den       (rsum_s4),
			.quo       (off[g])
		);
	end

	// contact when the root lies below the radius sum; overlap and contact point
	always_comb begin
		logic [32:0] ov_full;
		logic [33:0] c;
		ov_full       = {1'b0, geo_out.rsum} - {1'b0, sep_len};
		mid_c.touch   = geo_out.cand && !ov_full[32] && (ov_full != '0);
		mid_c.zd      = (sep_len == '0);
		mid_c.neg     = geo_out.neg;
		mid_c.pos     = geo_out.pos;
		mid_c.ad      = geo_out.ad;
		mid_c.ov      = ov_full[31:0];
		mid_c.sep_len = sep_len;
		for (int i = 0; i < 3; i++) begin
			if (geo_out.neg[i]) begin
				c = {{2{geo_out.p2[i][31]}}, geo_out.p2[i]} - {2'b00, off[i]};
			end else begin
				c = {{2{geo_out.p2[i][31]}}, geo_out.p2[i]} + {2'b00, off[i]};
			end
			if (c[33:31] == 3'b000 || c[33:31] == 3'b111) begin
				mid_c.contact[i] = c[31:0];
			end else if (c[33]) begin
				mid_c.contact[i] = 32'h8000_0000;
			end else begin
				mid_c.contact[i] = 32'h7FFF_FFFF;
			end
		end
	end

	// spring products: k*ov, then |d|*q and q*ov in 32-bit halves
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s13 <= mid_c;

			m_s14 <= m_s13;
			q_s14 <= stiffness_q * m_s13.ov;

			m_s15 <= m_s14;
			for (int i = 0; i < 3; i++) begin
				pl_s15[i] <= m_s14.ad[i] * q_s14[31:0];
				ph_s15[i] <= m_s14.ad[i] * q_s14[63:32];
			end
			el_s15 <= q_s14[31:0] * m_s14.ov;
			eh_s15 <= q_s14[63:32] * m_s14.ov;

			m_s16 <= m_s15;
			for (int i = 0; i < 3; i++) begin
				nf_s16[i] <= NF_W'((PROD_W'(pl_s15[i]) + (PROD_W'(ph_s15[i]) << 32))
					>> FRAC_BITS);
			end
			en_s16 <= EN_W'((PROD_W'(el_s15) + (PROD_W'(eh_s15) << 32))
				>> (2 * FRAC_BITS + 1));

			m_s17      <= m_s16;
			rem0_s17   <= rem0_c;
			sat_s17    <= sat_c;
			energy_s17 <= energy_c;
			for (int i = 0; i < 3; i++) begin
				lo_s17[i] <= nf_s16[i][FORCE_W-1:0];
			end
		end
	end

	// quotient of 2^48 or more when the top part already reaches the distance; energy saturates
	always_comb begin
		logic [CMP_W-1:0] hi_ext;
		logic [EX_W-1:0]  e_ext;
		for (int i = 0; i < 3; i++) begin
			hi_ext    = CMP_W'(nf_s16[i][NF_W-1:FORCE_W]);
			sat_c[i]  = hi_ext >= CMP_W'(m_s16.sep_len);
			rem0_c[i] = hi_ext[31:0];
		end
		e_ext = EX_W'(en_s16);
		if (|e_ext[EX_W-1:ENERGY_W]) begin
			energy_c = '1;
		end else begin
			energy_c = e_ext[ENERGY_W-1:0];
		end
	end

	for (g = 0; g < 3; g++) begin : g_force
		lecf_div #(
			.REM_W (32),
			.QUO_W (FORCE_W),
			.STEPS (lecf_pkg::FORCE_STEPS)
		) u_force_div (
			.clk       (clk),
			.en        (adv),
			.rem_start (rem0_s17[g]),
			.num       (lo_s17[g]),
			.den       (m_s17.sep_len),
			.quo       (quo[g])
		);
	end

	always_comb begin
		fin_in.touch   = m_s17.touch;
		fin_in.zd      = m_s17.zd;
		fin_in.pos     = m_s17.pos;
		fin_in.sat     = sat_s17;
		fin_in.contact = m_s17.contact;
		fin_in.energy  = energy_s17;
	end

	lecf_dly #(
		.W     ($bits(fin_t)),
		.DEPTH (FDIV_LAT)
	) u_fin_dly (
		.clk (clk),
		.en  (adv),
		.d   (fin_in),
		.q   (fin_out)
	);

	// clamp the magnitude and push against the separation; zero when apart or at zero distance
	always_comb begin
		logic [FORCE_W-1:0] mag;
		for (int i = 0; i < 3; i++) begin
			if (fin_out.pos[i]) begin
				mag = (fin_out.sat[i] || quo[i] > FORCE_MIN_MAG) ? FORCE_MIN_MAG : quo[i];
				force_c[i] = FORCE_W'(0) - mag;
			end else begin
				mag = (fin_out.sat[i] || quo[i] > FORCE_MAX) ? FORCE_MAX : quo[i];
				force_c[i] = mag;
			end
			if (!fin_out.touch || fin_out.zd) begin
				force_c[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			force_s26   <= force_c;
			touch_s26   <= fin_out.touch;
			contact_s26 <= fin_out.touch ? fin_out.contact : '0;
			energy_s26  <= fin_out.touch ? fin_out.energy : '0;
		end
	end

	assign result.valid         = vld_s[N_STG];
	assign result.force_x       = force_s26[0];
	assign result.force_y       = force_s26[1];
	assign result.force_z       = force_s26[2];
	assign result.contact_x     = contact_s26[0];
	assign result.contact_y     = contact_s26[1];
	assign result.contact_z     = contact_s26[2];
	assign result.touching      = touch_s26;
	assign result.spring_energy = energy_s26;

	a_apart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.touching |->
			result.force_x == '0 && result.force_y == '0 && result.force_z == '0 &&
			result.contact_x == '0 && result.contact_y == '0 &&
			result.contact_z == '0 && result.spring_energy == '0)
		else $error("non-zero result for a pair out of contact");

	a_slack_spring: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.touching && stiffness_q == '0 |->
			result.force_x == '0 && result.force_y == '0 && result.force_z == '0 &&
			result.spring_energy == '0)
		else $error("force or energy with zero stiffness");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("stage valid bits moved during a stall");

	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pair.ready)
		else $error("input taken while the output is blocked");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic signed [lecf_pkg::POS_W-1:0] first_x, first_y, first_z;
		logic        [lecf_pkg::RAD_W-1:0] first_radius;
		logic signed [lecf_pkg::POS_W-1:0] second_x, second_y, second_z;
		logic        [lecf_pkg::RAD_W-1:0] second_radius;
	} pair_t;

	typedef struct packed {
		logic signed [lecf_pkg::FORCE_W-1:0]  force_x, force_y, force_z;
		logic signed [lecf_pkg::POS_W-1:0]    contact_x, contact_y, contact_z;
		logic                                 touching;
		logic        [lecf_pkg::ENERGY_W-1:0] spring_energy;
	} contact_t;

	localparam int FB         = lecf_pkg::FRAC_BITS_DEF;
	localparam int DRAIN_WAIT = 40;
	localparam int STALL_MAX  = 4000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [lecf_pkg::K_W-1:0] cfg_wr_data;

	lecf_in_if  pair_bus ();
	lecf_out_if result_bus ();

	linear_elastic_contact_force_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pair        (pair_bus.sink),
		.result      (result_bus.source)
	);

	contact_t  expected_contacts[$];
	bit [31:0] spring_k;
	int        errors;
	int        gap_pct;
	int        stall_pct;
	int        hold_left;
	int        quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [63:0] int_root(bit [63:0] x);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic contact_t spring_contact(pair_t p, bit [31:0] k);
		contact_t   r;
		longint     p1[3], p2[3], d[3], c;
		bit [32:0]  ad[3];
		bit [63:0]  rsum, r2, sep_len, ov, q, off;
		bit [65:0]  sq_sum;
		bit [127:0] wide, quot, mag;
		r = '0;
		p1[0] = p.first_x;  p1[1] = p.first_y;  p1[2] = p.first_z;
		p2[0] = p.second_x; p2[1] = p.second_y; p2[2] = p.second_z;
		r2 = p.second_radius;
		rsum = r2 + p.first_radius;
		sq_sum = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = p1[i] - p2[i];
			ad[i] = 33'((d[i] < 0) ? -d[i] : d[i]);
			if (ad[i] >= rsum)
				return r;
			sq_sum += ad[i] * ad[i];
		end
		// the sum of squares must fit 64 bits and lie inside the radius sum
		if (sq_sum >= (66'd1 << 64) || sq_sum >= rsum * rsum)
			return r;
		sep_len = int_root(sq_sum[63:0]);
		ov = rsum - sep_len;
		q = k * ov;
		for (int i = 0; i < 3; i++) begin
			bit [lecf_pkg::FORCE_W-1:0] f;
			f = '0;
			if (sep_len != 0) begin
				wide = ad[i] * q;
				quot = (wide >> FB) / sep_len;
				if (d[i] > 0) begin
					mag = (quot > (128'd1 << 47)) ? (128'd1 << 47) : quot;
					f = -mag[lecf_pkg::FORCE_W-1:0];
				end else begin
					mag = (quot > (128'd1 << 47) - 1) ? (128'd1 << 47) - 1 : quot;
					f = mag[lecf_pkg::FORCE_W-1:0];
				end
			end
			off = (r2 * ad[i]) / rsum;
			c = p2[i] + ((d[i] < 0) ? -longint'(off) : longint'(off));
			if (c > 64'sd2147483647)
				c = 64'sd2147483647;
			if (c < -64'sd2147483648)
				c = -64'sd2147483648;
			case (i)
				0: begin r.force_x = f; r.contact_x = c[31:0]; end
				1: begin r.force_y = f; r.contact_y = c[31:0]; end
				default: begin r.force_z = f; r.contact_z = c[31:0]; end
			endcase
		end
		r.touching = 1'b1;
		wide = (128'(q) * ov) >> (2 * FB + 1);
		r.spring_energy = (wide > 128'hFFFF_FFFF_FFFF) ? '1 :
			wide[lecf_pkg::ENERGY_W-1:0];
		return r;
	endfunction

	// result side: stall, check, watchdog
	always @(posedge clk) begin
		contact_t got, want;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got = '{result_bus.force_x, result_bus.force_y, result_bus.force_z,
				result_bus.contact_x, result_bus.contact_y, result_bus.contact_z,
				result_bus.touching, result_bus.spring_energy};
			if (expected_contacts.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				errors++;
			end else begin
				want = expected_contacts.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, got);
					errors++;
				end
			end
		end
		if ((pair_bus.valid && pair_bus.ready) || (result_bus.valid && result_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_MAX);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_pair(pair_t p);
		while ($urandom_range(0, 99) < gap_pct) begin
			pair_bus.valid <= 1'b0;
			@(posedge clk);
		end
		{pair_bus.first_x, pair_bus.first_y, pair_bus.first_z, pair_bus.first_radius,
			pair_bus.second_x, pair_bus.second_y, pair_bus.second_z,
			pair_bus.second_radius} <= p;
		pair_bus.valid <= 1'b1;
		do
			@(posedge clk);
		while (!pair_bus.ready);
		expected_contacts.push_back(spring_contact(p, spring_k));
	endtask

	task automatic drain();
		pair_bus.valid <= 1'b0;
		while (expected_contacts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_stiffness(bit [31:0] k);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		spring_k = k;
	endtask

	function automatic pair_t random_pair();
		pair_t     p;
		int        mode, s;
		bit [63:0] rsum;
		longint    dl;
		mode = $urandom_range(0, 9);
		p = pair_t'({$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		if (mode < 8) begin
			// overlapping pair: second placed within the radius sum of the first
			s = (mode < 6) ? $urandom_range(4, 24) : $urandom_range(25, 31);
			p.first_radius  = 31'($urandom >> (32 - s));
			p.second_radius = 31'($urandom >> (32 - s));
			rsum = p.first_radius + p.second_radius + 1;
			dl = longint'({$urandom, $urandom} % rsum) - longint'(rsum / 2);
			p.second_x = p.first_x - dl[31:0];
			dl = longint'({$urandom, $urandom} % rsum) - longint'(rsum / 2);
			p.second_y = p.first_y - dl[31:0];
			dl = longint'({$urandom, $urandom} % rsum) - longint'(rsum / 2);
			p.second_z = p.first_z - dl[31:0];
		end
		return p;
	endfunction

	task automatic random_phase(int n, int gp, int sp);
		gap_pct   = gp;
		stall_pct = sp;
		repeat (n) send_pair(random_pair());
	endtask

	task automatic test_special_cases();
		bit [31:0] ks[3] = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000};
		bit [30:0] rmax = '1;
		gap_pct = 0;
		stall_pct = 0;
		foreach (ks[j]) begin
			write_stiffness(ks[j]);
			// coincident centres
			send_pair('{0, 0, 0, 31'h64_0000, 0, 0, 0, 31'h32_0000});
			// far apart
			send_pair('{32'h100_0000, 0, 0, 31'h1_0000, 0, 0, 0, 31'h1_0000});
			// both radii zero
			send_pair('{5, 5, 5, 0, 5, 5, 5, 0});
			// one overlapping pair and one just apart, first ahead and behind on each axis
			send_pair('{32'h3_0000, 32'hFFFF_0000, 32'h8000, 31'h2_0000, 0, 0, 0, 31'h2_0000});
			send_pair('{32'hFFFD_0000, 32'h1_0000, 32'hFFFF_8000, 31'h2_0000,
				0, 0, 0, 31'h1_0000});
			// largest radii, far ends of the range
			send_pair('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, rmax,
				32'h7FFF_0000, 32'h8000_0000, 32'h8000_0000, rmax});
			send_pair('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, rmax,
				32'h8000_1000, 32'h8000_1000, 32'h8000_0000, rmax});
		end
	endtask

	task automatic test_no_idle();
		write_stiffness(32'h0004_0000);
		random_phase(280, 0, 0);
	endtask

	task automatic test_sender_idle();
		write_stiffness($urandom);
		random_phase(280, 53, 0);
	endtask

	task automatic test_receiver_stall();
		write_stiffness(32'hFFFF_FFFF);
		random_phase(280, 0, 53);
	endtask

	task automatic test_both_idle();
		write_stiffness(32'd1);
		random_phase(280, 27, 27);
	endtask

	task automatic test_backpressure();
		write_stiffness(32'h0010_0000);
		hold_left = 400;
		random_phase(150, 0, 0);
	endtask

	task automatic test_mixed_idle();
		write_stiffness(0);
		random_phase(120, 27, 27);
		write_stiffness($urandom >> $urandom_range(0, 31));
		random_phase(280, $urandom_range(0, 53), $urandom_range(0, 53));
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		pair_bus.valid = 1'b0;
		{pair_bus.first_x, pair_bus.first_y, pair_bus.first_z, pair_bus.first_radius,
			pair_bus.second_x, pair_bus.second_y, pair_bus.second_z,
			pair_bus.second_radius} = '0;
		result_bus.ready = 1'b0;
		spring_k     = 0;
		errors       = 0;
		gap_pct      = 0;
		stall_pct    = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_mixed_idle();
		stall_pct = 0;
		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== linear_elastic_contact_force_top.f =====
rtl/lecf_pkg.sv
rtl/lecf_in_if.sv
rtl/lecf_out_if.sv
rtl/lecf_sqrt.sv
rtl/lecf_div.sv
rtl/lecf_dly.sv
rtl/linear_elastic_contact_force_top.sv
tb/testbench.sv
